// ----- design/lxld_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the 9-bit literal/zero-run decompressor.
// No dependencies; every design file takes names from here by scope.
package lxld_pkg;

	localparam int BYTE_W    = 8;
	localparam int CODE_W    = 9;
	localparam int LANES     = 4;
	localparam int COUNT_W   = 3;
	localparam int HELD_W    = 4;
	localparam int SHIFT_W   = 3;
	localparam int LIT_BIT   = 8;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 2;
	localparam logic [CODE_W-1:0] END_CODE = '0;

	// Command passed from the front end to the back end
	typedef enum logic [1:0] {
		CMD_LIT,
		CMD_RUN,
		CMD_STAT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [BYTE_W-1:0]  value;  // literal byte or zero-run length
		logic               fin;    // closes the stream
		logic               ferr;   // leftover bits at stream close
	} cmd_t;

	typedef enum logic {
		BK_HEAD,
		BK_RUN
	} back_state_t;

endpackage

// ----- design/lxld_front.sv -----
`timescale 1ns / 1ps
// Front end: unpacks compressed bytes MSB first into 9-bit codes and
// turns each code into a command for the back end. Uses lxld_pkg.
module lxld_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [lxld_pkg::BYTE_W-1:0] data_byte,
	input  logic                       final_byte,
	input  logic                       q_full,
	output logic                       push,
	output lxld_pkg::cmd_t             cmd
);

	logic [lxld_pkg::BYTE_W-1:0]  bit_store_q;
	logic [lxld_pkg::HELD_W-1:0]  bits_held_q;
	logic                         end_seen_q;

	logic                         accept;
	logic [2*lxld_pkg::BYTE_W-1:0] acc;
	logic [lxld_pkg::SHIFT_W-1:0] shamt;
	logic [lxld_pkg::CODE_W-1:0]  code;
	logic                         have_code;
	logic [lxld_pkg::HELD_W-1:0]  held_d;
	logic [lxld_pkg::BYTE_W-1:0]  keep_mask;
	logic [lxld_pkg::BYTE_W-1:0]  store_d;
	logic                         end_d;
	logic                         emits;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && !q_full;

	// Extract one code from the held bits plus the new byte
	assign acc       = {bit_store_q, data_byte};
	assign shamt     = lxld_pkg::SHIFT_W'(bits_held_q - lxld_pkg::HELD_W'(1));
	assign code      = lxld_pkg::CODE_W'(acc >> shamt);
	assign have_code = (bits_held_q != '0);
	assign held_d    = have_code ? bits_held_q - lxld_pkg::HELD_W'(1)
	                             : lxld_pkg::HELD_W'(lxld_pkg::BYTE_W);
	assign keep_mask = lxld_pkg::BYTE_W'((10'(1) << held_d) - 10'(1));
	assign store_d   = data_byte & keep_mask;
	assign end_d     = end_seen_q || (have_code && (code == lxld_pkg::END_CODE));

	// Classify the code into a command
	always_comb begin
		cmd.value = code[lxld_pkg::BYTE_W-1:0];
		cmd.fin   = final_byte;
		cmd.ferr  = (held_d != '0);
		emits     = have_code && !end_seen_q && (code != lxld_pkg::END_CODE);
		if (code[lxld_pkg::LIT_BIT]) begin
			cmd.kind = lxld_pkg::CMD_LIT;
		end else begin
			cmd.kind = lxld_pkg::CMD_RUN;
		end
		if (!emits) begin
			cmd.kind = lxld_pkg::CMD_STAT;
		end
		push = accept && (emits || final_byte);
	end

	// Advance the unpacker; clear everything at stream close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_store_q <= '0;
			bits_held_q <= '0;
			end_seen_q  <= 1'b0;
		end else if (accept) begin
			if (final_byte) begin
				bit_store_q <= '0;
				bits_held_q <= '0;
				end_seen_q  <= 1'b0;
			end else begin
				bit_store_q <= store_d;
				bits_held_q <= held_d;
				end_seen_q  <= end_d;
			end
		end
	end

endmodule

// ----- design/lxld_cmd_fifo.sv -----
`timescale 1ns / 1ps
// Two-entry command queue between front end and back end.
// Uses lxld_pkg::cmd_t.
module lxld_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lxld_pkg::cmd_t cmd_in,
	input  logic           pop,
	output lxld_pkg::cmd_t head,
	output logic           head_valid,
	output logic           full
);

	lxld_pkg::cmd_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != 2'd0);
	assign full       = (count_q == 2'd2);

	// Store the pushed command; start from a known head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_q[0] <= '0;
			mem_q[1] <= '0;
		end else if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Track pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- design/lxld_back.sv -----
`timescale 1ns / 1ps
// Back end: expands commands into bytes, applies the lagged XOR through a
// byte shift line and packs up to four bytes per output transaction. Uses lxld_pkg.
module lxld_back #(
	parameter int XOR_LAG = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	input  lxld_pkg::cmd_t                    head,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lxld_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tlast,
	output logic [lxld_pkg::OUT_USER_W-1:0]   m_tuser
);

	localparam int LANES = lxld_pkg::LANES;
	localparam int CW    = $clog2(XOR_LAG + 1);
	localparam int POOL  = XOR_LAG + LANES;
	localparam int PW    = $clog2(POOL);

	lxld_pkg::back_state_t state_q, state_d;

	logic [lxld_pkg::BYTE_W-1:0]  hist_q [XOR_LAG];
	logic [lxld_pkg::BYTE_W-1:0]  pool [POOL];
	logic [CW-1:0]                cnt_q;
	logic [CW:0]                  cnt_sum;
	logic [lxld_pkg::BYTE_W-1:0]  run_left_q;
	logic [lxld_pkg::BYTE_W-1:0]  rem;

	logic                         emit;
	logic                         done;
	logic [lxld_pkg::COUNT_W-1:0] k;
	logic [lxld_pkg::BYTE_W-1:0]  lane [LANES];

	logic                         out_valid_q;
	logic [lxld_pkg::BYTE_W-1:0]  out_lane_q [LANES];
	logic [lxld_pkg::COUNT_W-1:0] out_count_q;
	logic                         out_last_q;
	logic                         out_end_q;
	logic                         out_ferr_q;

	assign emit = head_valid && (!out_valid_q || m_tready);
	assign rem  = (state_q == lxld_pkg::BK_RUN) ? run_left_q : head.value;

	// Next state: stay in a zero run until its last group goes out
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lxld_pkg::BK_HEAD: begin
				if (emit && (head.kind == lxld_pkg::CMD_RUN) && !done) begin
					state_d = lxld_pkg::BK_RUN;
				end
			end
			lxld_pkg::BK_RUN: begin
				if (emit && done) begin
					state_d = lxld_pkg::BK_HEAD;
				end
			end
			default: state_d = lxld_pkg::BK_HEAD;
		endcase
	end

	// Outputs: byte count of this group and whether the command finishes
	always_comb begin
		unique case (head.kind)
			lxld_pkg::CMD_LIT: begin
				k    = lxld_pkg::COUNT_W'(1);
				done = 1'b1;
			end
			lxld_pkg::CMD_RUN: begin
				if (rem > lxld_pkg::BYTE_W'(LANES)) begin
					k    = lxld_pkg::COUNT_W'(LANES);
					done = 1'b0;
				end else begin
					k    = rem[lxld_pkg::COUNT_W-1:0];
					done = 1'b1;
				end
			end
			default: begin
				k    = '0;
				done = 1'b1;
			end
		endcase
		pop = emit && done;
	end

	// XOR each lane with the byte XOR_LAG positions back, once history is full
	always_comb begin
		logic [lxld_pkg::BYTE_W-1:0] raw;
		logic                        full_j;
		for (int j = 0; j < LANES; j++) begin
			raw    = ((j == 0) && (head.kind == lxld_pkg::CMD_LIT)) ? head.value : '0;
			full_j = (({1'b0, cnt_q} + (CW+1)'(j)) >= (CW+1)'(XOR_LAG));
			if (lxld_pkg::COUNT_W'(j) < k) begin
				lane[j] = raw ^ (full_j ? hist_q[XOR_LAG-1-j] : '0);
			end else begin
				lane[j] = '0;
			end
		end
	end

	// Pool of new bytes (newest first) ahead of the old history
	always_comb begin
		for (int m = 0; m < LANES; m++) begin
			pool[m] = lane[LANES-1-m];
		end
		for (int m = 0; m < XOR_LAG; m++) begin
			pool[LANES+m] = hist_q[m];
		end
	end

	assign cnt_sum = {1'b0, cnt_q} + (CW+1)'(k);

	// Shift the history line by the number of bytes emitted
	always_ff @(posedge clk) begin
		if (emit) begin
			for (int i = 0; i < XOR_LAG; i++) begin
				hist_q[i] <= pool[PW'(i) + PW'(LANES) - PW'(k)];
			end
		end
	end

	// Control state: sequencer, history fill and run counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lxld_pkg::BK_HEAD;
			cnt_q      <= '0;
			run_left_q <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				if (pop && head.fin) begin
					cnt_q <= '0;
				end else if (cnt_sum >= (CW+1)'(XOR_LAG)) begin
					cnt_q <= CW'(XOR_LAG);
				end else begin
					cnt_q <= cnt_sum[CW-1:0];
				end
				if (!done) begin
					run_left_q <= rem - lxld_pkg::BYTE_W'(LANES);
				end
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			for (int j = 0; j < LANES; j++) begin
				out_lane_q[j] <= lane[j];
			end
			out_count_q <= k;
			out_last_q  <= pop;
			out_end_q   <= pop && head.fin;
			out_ferr_q  <= pop && head.fin && head.ferr;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_ferr_q, out_end_q};
	assign m_tdata  = {(lxld_pkg::OUT_DATA_W - LANES*lxld_pkg::BYTE_W - lxld_pkg::COUNT_W)'(0),
	                   out_count_q, out_lane_q[3], out_lane_q[2], out_lane_q[1], out_lane_q[0]};

endmodule

// ----- design/lre_xor_log_decompressor.sv -----
`timescale 1ns / 1ps
// Decompressor top: front end -> two-entry command queue -> back end.
// A result passes through the command queue and the output register. Throughput: one input
// byte per cycle while codes are literals and the output is not stalled; a zero run of N bytes
// holds the back end while it goes out in groups of up to four bytes.
// Reset (arst_n low, asynchronous) clears unpacker, queue, sequencer and history fill;
// the unpacker is cleared again when a closing byte is accepted, the history fill when its command is popped.
module lre_xor_log_decompressor #(
	parameter int XOR_LAG = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // [7:0] data_byte
	input  logic                            s_tlast,  // final_byte
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] out_byte0, [15:8] out_byte1, [23:16] out_byte2, [31:24] out_byte3,
	// [34:32] bytes_valid, [39:35] zero
	output logic [lxld_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                            m_tlast,  // last_of_run
	output logic [lxld_pkg::OUT_USER_W-1:0] m_tuser   // [0] stream_end, [1] format_error
);

	logic           push;
	logic           pop;
	logic           q_full;
	logic           head_valid;
	lxld_pkg::cmd_t cmd;
	lxld_pkg::cmd_t head;

	lxld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.data_byte  (s_tdata),
		.final_byte (s_tlast),
		.q_full     (q_full),
		.push       (push),
		.cmd        (cmd)
	);

	lxld_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.cmd_in     (cmd),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (q_full)
	);

	lxld_back #(
		.XOR_LAG (XOR_LAG)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

// ----- dv/lre_xor_log_decompressor_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the literal/zero-run decompressor with lagged XOR.
// Depends on design/lxld_pkg.sv and design/lre_xor_log_decompressor.sv.

// Tracks the decoder state and holds the output transactions still to come
class decomp_scoreboard;
	localparam int LAG = 32;

	typedef struct packed {
		logic [31:0] lanes;
		logic [2:0]  count;
		logic        last;
		logic        send;
		logic        ferr;
	} beat_t;

	beat_t       beats_due[$];
	int          errors;

	logic [7:0]  spill_bits;
	int unsigned spill_count;
	bit          end_code_seen;
	logic [7:0]  past_bytes [LAG];
	int unsigned past_idx;
	bit          past_wrapped;

	beat_t       open_beat;
	int unsigned open_fill;
	int unsigned beats_made;

	function new();
		errors = 0;
		clear_stream();
	endfunction

	function void clear_stream();
		spill_bits    = '0;
		spill_count   = 0;
		end_code_seen = 0;
		past_idx      = 0;
		past_wrapped  = 0;
		foreach (past_bytes[i])
			past_bytes[i] = '0;
	endfunction

	// XOR one byte against the history and pack it into the open beat
	function void emit_byte(logic [7:0] b);
		if (past_wrapped)
			b = b ^ past_bytes[past_idx];
		past_bytes[past_idx] = b;
		if (past_idx == LAG - 1) begin
			past_idx     = 0;
			past_wrapped = 1;
		end else begin
			past_idx++;
		end
		open_beat.lanes[open_fill*8 +: 8] = b;
		open_fill++;
		if (open_fill == 4) begin
			open_beat.count = 3'd4;
			beats_due.insert(beats_due.size(), open_beat);
			beats_made++;
			open_beat = '0;
			open_fill = 0;
		end
	endfunction

	// Predict the output transactions caused by one accepted input byte
	function void note_byte(logic [7:0] data, logic fin);
		logic [15:0] acc;
		logic [8:0]  code;
		int unsigned total;
		beat_t       stat;
		acc        = {spill_bits, data};
		total      = spill_count + 8;
		open_beat  = '0;
		open_fill  = 0;
		beats_made = 0;
		if (total >= 9) begin
			code  = 9'(acc >> (total - 9));
			total = total - 9;
			if (!end_code_seen) begin
				if (code[8]) begin
					emit_byte(code[7:0]);
				end else if (code == '0) begin
					end_code_seen = 1;
				end else begin
					for (int k = 0; k < code; k++)
						emit_byte(8'h00);
				end
			end
		end
		spill_bits  = 8'(acc & ((16'h1 << total) - 16'h1));
		spill_count = total;
		// flush a partly filled beat
		if (open_fill > 0) begin
			open_beat.count = 3'(open_fill);
			beats_due.insert(beats_due.size(), open_beat);
			beats_made++;
		end
		if (!fin) begin
			if (beats_made > 0)
				beats_due[$].last = 1'b1;
			return;
		end
		// stream close: status-only beat when nothing was emitted
		if (beats_made == 0) begin
			stat = '0;
			beats_due.insert(beats_due.size(), stat);
		end
		beats_due[$].last = 1'b1;
		beats_due[$].send = 1'b1;
		beats_due[$].ferr = (spill_count != 0);
		clear_stream();
	endfunction

	function void compare_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Check one accepted output transaction against the oldest prediction
	function void check_beat(logic [39:0] tdata, logic tlast, logic [1:0] tuser);
		beat_t want;
		if (beats_due.size() == 0) begin
			$display("%0t: unexpected output, expected none actual %0h", $time, tdata);
			errors++;
			return;
		end
		want = beats_due.pop_front();
		for (int i = 0; i < 4; i++)
			compare_field($sformatf("out_byte%0d", i), want.lanes[i*8 +: 8], tdata[i*8 +: 8]);
		compare_field("bytes_valid", want.count, tdata[34:32]);
		compare_field("tdata pad", 0, tdata[39:35]);
		compare_field("last_of_run", want.last, tlast);
		compare_field("stream_end", want.send, tuser[0]);
		compare_field("format_error", want.ferr, tuser[1]);
	endfunction

	function int pending();
		return beats_due.size();
	endfunction
endclass

module lre_xor_log_decompressor_test;

	localparam int RANDOM_BYTES = 325;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} in_byte_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [7:0]                      s_tdata = '0;   // [7:0] data_byte
	logic                            s_tlast = 1'b0; // final_byte
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	// [7:0] out_byte0 .. [31:24] out_byte3, [34:32] bytes_valid, [39:35] zero
	logic [lxld_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            m_tlast;        // last_of_run
	logic [lxld_pkg::OUT_USER_W-1:0] m_tuser;        // [0] stream_end, [1] format_error

	decomp_scoreboard sb = new();
	in_byte_t         feed_q[$];
	bit               code_bits[$];
	bit               calm = 0;
	int               quiet_cycles = 0;

	lre_xor_log_decompressor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void add_byte(logic [7:0] data, logic fin);
		in_byte_t item;
		item.data = data;
		item.fin  = fin;
		feed_q.insert(feed_q.size(), item);
	endfunction

	function automatic void push_code(logic [8:0] code);
		for (int i = 8; i >= 0; i--)
			code_bits.insert(code_bits.size(), code[i]);
	endfunction

	// Pad the collected codes to whole bytes and queue them, last one final
	function automatic void close_stream();
		logic [7:0] b;
		int         nbytes;
		while (code_bits.size() % 8 != 0)
			code_bits.insert(code_bits.size(), 1'($urandom_range(1)));
		nbytes = code_bits.size() / 8;
		for (int i = 0; i < nbytes; i++) begin
			for (int j = 0; j < 8; j++)
				b = {b[6:0], code_bits.pop_front()};
			add_byte(b, i == nbytes - 1);
		end
	endfunction

	function automatic logic [8:0] pick_code();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return {1'b1, 8'($urandom_range(255))};
		else if (r < 95)
			return 9'($urandom_range(8, 1));
		else
			return 9'($urandom_range(255, 9));
	endfunction

	function automatic void build_stimulus();
		int start_len;
		int ncodes;
		int end_at;
		int r;
		// well-formed stream: literal extremes, shortest and longest runs,
		// end code, then a code that must be ignored
		push_code(9'h100);
		push_code(9'h1FF);
		push_code(9'h001);
		push_code(9'h0FF);
		push_code(9'h003);
		push_code(9'h1A5);
		push_code(lxld_pkg::END_CODE);
		push_code(9'h1FF);
		close_stream();
		// final byte with no code: status-only close with leftover bits
		add_byte(8'hFF, 1'b1);
		add_byte(8'h00, 1'b1);
		// one literal, then leftover bits on the final byte
		push_code(9'h1C3);
		close_stream();
		// end code right away, nothing emitted
		push_code(lxld_pkg::END_CODE);
		for (int i = 0; i < 7; i++)
			push_code(9'h100 | 9'(i));
		close_stream();

		start_len = feed_q.size();
		while (feed_q.size() < start_len + RANDOM_BYTES) begin
			r = $urandom_range(99);
			if (r < 10) begin
				// noise: loose bytes with a random final flag
				repeat ($urandom_range(4, 1))
					add_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
			end else begin
				if (r < 75)
					ncodes = 8 * $urandom_range(3, 1);
				else
					ncodes = $urandom_range(20, 1);
				end_at = ($urandom_range(3) == 0) ? $urandom_range(ncodes - 1) : ncodes;
				for (int i = 0; i < ncodes; i++) begin
					if (i == end_at)
						push_code(lxld_pkg::END_CODE);
					else if (i > end_at)
						push_code(9'($urandom_range(511)));
					else
						push_code(pick_code());
				end
				close_stream();
			end
		end
	endfunction

	// Drive input bytes; hold each one until accepted
	task automatic feed_bytes();
		int idx;
		idx = 0;
		while (idx < feed_q.size() || s_tvalid) begin
			@(posedge clk);
			if (s_tvalid && s_tready) begin
				sb.note_byte(s_tdata, s_tlast);
				idx++;
			end
			calm = (idx >= 120 && idx < 200);
			if (s_tvalid && !s_tready) begin
				// hold the pending transaction
			end else if (idx < feed_q.size() && (calm || $urandom_range(99) >= 23)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= feed_q[idx].data;
				s_tlast  <= feed_q[idx].fin;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	endtask

	// Accept and check output transactions, stall at random
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_beat(m_tdata, m_tlast, m_tuser);
		m_tready <= calm || ($urandom_range(99) >= 23);
	end

	// Abort when no transaction moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		build_stimulus();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		feed_bytes();
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/lxld_pkg.sv
design/lxld_front.sv
design/lxld_cmd_fifo.sv
design/lxld_back.sv
design/lre_xor_log_decompressor.sv
dv/lre_xor_log_decompressor_test.sv
